// ----- hdl/cdt_pkg.sv -----
// ----------------------------------------------------------------------------
// cdt_pkg
// Types, constants and helpers shared by the date-time interval adder.
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int DIV_W  = 18;   // dividend / quotient width, covers every year value
    localparam int DVSR_W = 9;    // divisor / remainder width, covers the 400-year cycle

    // reciprocals are ceil(2^RECIP_SHIFT / divisor); exact for every DIV_W-bit dividend
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 27;

    localparam logic [DVSR_W-1:0] SEC_PER_MIN   = 9'd60;
    localparam logic [DVSR_W-1:0] MIN_PER_HOUR  = 9'd60;
    localparam logic [DVSR_W-1:0] HOUR_PER_DAY  = 9'd24;
    localparam logic [DVSR_W-1:0] MON_PER_YEAR  = 9'd12;
    localparam logic [DVSR_W-1:0] GREG_CYCLE    = 9'd400;
    localparam logic [DVSR_W-1:0] GREG_CYCLE_LAST = 9'd399;
    localparam logic [DVSR_W-1:0] CENTURY_1     = 9'd100;
    localparam logic [DVSR_W-1:0] CENTURY_2     = 9'd200;
    localparam logic [DVSR_W-1:0] CENTURY_3     = 9'd300;

    localparam logic [RECIP_W-1:0] RECIP_60  = 24'd2236963;
    localparam logic [RECIP_W-1:0] RECIP_24  = 24'd5592406;
    localparam logic [RECIP_W-1:0] RECIP_12  = 24'd11184811;
    localparam logic [RECIP_W-1:0] RECIP_400 = 24'd335545;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    typedef struct packed {
        logic [15:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [4:0]  start_hour;
        logic [5:0]  start_minute;
        logic [5:0]  start_second;
        logic [11:0] add_years;
        logic [11:0] add_months;
        logic [15:0] add_days;
        logic [15:0] add_hours;
        logic [15:0] add_minutes;
        logic [15:0] add_seconds;
    } request_t;

    typedef struct packed {
        logic [15:0] sum_year;
        logic [3:0]  sum_month;
        logic [4:0]  sum_day;
        logic [4:0]  sum_hour;
        logic [5:0]  sum_minute;
        logic [5:0]  sum_second;
        logic        year_overflow;
    } result_t;

    typedef struct packed {
        logic              go;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quot;
        logic [DVSR_W-1:0] rem;
    } div_res_t;

    // leap test on the year's position inside the 400-year cycle
    function automatic logic leap_of(input logic [DVSR_W-1:0] ymod);
        logic century;
        century = (ymod == CENTURY_1) || (ymod == CENTURY_2) || (ymod == CENTURY_3);
        return (ymod[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month == MON_FEB)
            len = leap ? 5'd29 : 5'd28;
        else if ((month == MON_APR) || (month == MON_JUN) ||
                 (month == MON_SEP) || (month == MON_NOV))
            len = 5'd30;
        else
            len = 5'd31;
        return len;
    endfunction

    function automatic logic [RECIP_W-1:0] recip_of(input logic [DVSR_W-1:0] divisor);
        logic [RECIP_W-1:0] recip;
        case (divisor)
            SEC_PER_MIN:  recip = RECIP_60;   // minutes per hour share this value
            HOUR_PER_DAY: recip = RECIP_24;
            MON_PER_YEAR: recip = RECIP_12;
            GREG_CYCLE:   recip = RECIP_400;
            default:      recip = '0;
        endcase
        return recip;
    endfunction

endpackage

// ----- hdl/cdt_div.sv -----
// ----------------------------------------------------------------------------
// cdt_div
// Reciprocal-multiply divider for the fixed carry divisors, shared by all
// carry steps; the quotient, the back product and the remainder are registered in turn.
// ----------------------------------------------------------------------------
module cdt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  cdt_pkg::div_req_t req,
    output cdt_pkg::div_res_t res
);

    localparam int DW = cdt_pkg::DIV_W;
    localparam int RW = cdt_pkg::DVSR_W;
    localparam int MW = cdt_pkg::RECIP_W;
    localparam int SH = cdt_pkg::RECIP_SHIFT;
    localparam int PW = DW + MW;
    localparam int QW = PW - SH;
    localparam int BW = QW + RW;

    logic [2:0]    stage_reg, stage_next;
    logic          done_reg, done_next;
    logic [DW-1:0] num_reg, num_next;
    logic [RW-1:0] dvsr_reg, dvsr_next;
    logic [MW-1:0] recip_reg, recip_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [DW-1:0] back_reg, back_next;
    logic [RW-1:0] rem_reg, rem_next;

    always_comb
    begin
        stage_next = {stage_reg[1:0], req.go};
        done_next  = stage_reg[2];
        num_next   = num_reg;
        dvsr_next  = dvsr_reg;
        recip_next = recip_reg;
        quo_next   = quo_reg;
        back_next  = back_reg;
        rem_next   = rem_reg;
        if (req.go)
        begin
            num_next   = req.dividend;
            dvsr_next  = req.divisor;
            recip_next = cdt_pkg::recip_of(req.divisor);
        end
        if (stage_reg[0])
        begin
            // quotient from the scaled reciprocal
            quo_next = QW'((PW'(num_reg) * PW'(recip_reg)) >> SH);
        end
        if (stage_reg[1])
        begin
            back_next = DW'(BW'(quo_reg) * BW'(dvsr_reg));
        end
        if (stage_reg[2])
        begin
            rem_next = RW'(num_reg - back_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        dvsr_reg  <= dvsr_next;
        recip_reg <= recip_next;
        quo_reg   <= quo_next;
        back_reg  <= back_next;
        rem_reg   <= rem_next;
    end

    assign res.done = done_reg;
    assign res.quot = DW'(quo_reg);
    assign res.rem  = rem_reg;

    ap_done_after_stages: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(stage_reg[2])) else $error("divider done without a run");
    ap_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dvsr_reg)) else $error("divider remainder out of range");
    ap_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.go |-> (stage_reg == 3'b000)) else $error("divider request while running");

endmodule

// ----- hdl/calendar_datetime_add_interval.sv -----
// ----------------------------------------------------------------------------
// calendar_datetime_add_interval
// Adds a years/months/days/hours/minutes/seconds interval to a Gregorian
// date-time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the sum is ready, the sum then stays on result, and done is high for
// exactly one cycle. The receiver cannot stall, so capture result whenever
// done is seen. Busy covers the five carry divisions (one shared
// reciprocal-multiply divider, which finishes each division before the next),
// one walk step per month crossed, plus one for the last partial month, and
// one more to finish: the largest day count, about 68300 days, takes about
// 2245 month steps. The day is not clamped after the month shift, and
// year_overflow flags a sum year above 65535 (sum_year then holds its low 16
// bits).
module calendar_datetime_add_interval (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cdt_pkg::request_t request,
    output logic              busy,
    output logic              done,
    output cdt_pkg::result_t  result
);

    localparam int DW = cdt_pkg::DIV_W;
    localparam int RW = cdt_pkg::DVSR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEC,
        ST_MIN,
        ST_HOUR,
        ST_MON,
        ST_YEAR,
        ST_WALK
    } state_t;

    state_t            state_reg, state_next;
    cdt_pkg::request_t req_reg, req_next;
    cdt_pkg::result_t  result_reg, result_next;
    logic              done_reg, done_next;
    logic [DW-1:0]     year_reg, year_next;
    logic [RW-1:0]     ymod_reg, ymod_next;
    logic [3:0]        month_reg, month_next;
    logic [4:0]        day_reg, day_next;
    logic [4:0]        hour_reg, hour_next;
    logic [5:0]        minute_reg, minute_next;
    logic [5:0]        second_reg, second_next;
    logic [DW-1:0]     days_reg, days_next;

    cdt_pkg::div_req_t div_req;
    cdt_pkg::div_res_t div_res;

    logic [4:0]    mlen;
    logic [6:0]    left;
    logic [DW-1:0] left_ext;
    logic [3:0]    start_mon;
    logic [DW-1:0] year_sum;

    cdt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign mlen      = cdt_pkg::month_len(month_reg, cdt_pkg::leap_of(ymod_reg));
    assign left      = {2'b00, mlen} - {2'b00, day_reg};
    assign left_ext  = {{(DW-7){left[6]}}, left};
    assign start_mon = (req_reg.start_month == 4'd0) ? cdt_pkg::MON_JAN : req_reg.start_month;
    assign year_sum  = DW'(req_reg.start_year) + DW'(req_reg.add_years) + div_res.quot;

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        year_next   = year_reg;
        ymod_next   = ymod_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        days_next   = days_reg;
        div_req     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next         = request;
                    div_req.go       = 1'b1;
                    div_req.dividend = DW'(request.start_second) + DW'(request.add_seconds);
                    div_req.divisor  = cdt_pkg::SEC_PER_MIN;
                    state_next       = ST_SEC;
                end
            end
            ST_SEC:
            begin
                if (div_res.done)
                begin
                    second_next      = div_res.rem[5:0];
                    div_req.go       = 1'b1;
                    div_req.dividend = DW'(req_reg.start_minute) + DW'(req_reg.add_minutes)
                                       + div_res.quot;
                    div_req.divisor  = cdt_pkg::MIN_PER_HOUR;
                    state_next       = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (div_res.done)
                begin
                    minute_next      = div_res.rem[5:0];
                    div_req.go       = 1'b1;
                    div_req.dividend = DW'(req_reg.start_hour) + DW'(req_reg.add_hours)
                                       + div_res.quot;
                    div_req.divisor  = cdt_pkg::HOUR_PER_DAY;
                    state_next       = ST_HOUR;
                end
            end
            ST_HOUR:
            begin
                if (div_res.done)
                begin
                    hour_next        = div_res.rem[4:0];
                    days_next        = DW'(req_reg.add_days) + div_res.quot;
                    div_req.go       = 1'b1;
                    div_req.dividend = DW'(start_mon) + DW'(req_reg.add_months) - DW'(1);
                    div_req.divisor  = cdt_pkg::MON_PER_YEAR;
                    state_next       = ST_MON;
                end
            end
            ST_MON:
            begin
                if (div_res.done)
                begin
                    month_next       = div_res.rem[3:0] + 4'd1;
                    year_next        = year_sum;
                    day_next         = req_reg.start_day;
                    div_req.go       = 1'b1;
                    div_req.dividend = year_sum;
                    div_req.divisor  = cdt_pkg::GREG_CYCLE;
                    state_next       = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (div_res.done)
                begin
                    ymod_next  = div_res.rem;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (days_reg == '0)
                begin
                    result_next.sum_year      = year_reg[15:0];
                    result_next.sum_month     = month_reg;
                    result_next.sum_day       = day_reg;
                    result_next.sum_hour      = hour_reg;
                    result_next.sum_minute    = minute_reg;
                    result_next.sum_second    = second_reg;
                    result_next.year_overflow = |year_reg[DW-1:16];
                    done_next                 = 1'b1;
                    state_next                = ST_IDLE;
                end
                else if (!left[6] && (left != '0) && (days_reg <= left_ext))
                begin
                    // the rest fits inside this month
                    day_next  = day_reg + days_reg[4:0];
                    days_next = '0;
                end
                else
                begin
                    // leave the month: a negative remainder grows the day count
                    days_next = days_reg - left_ext - DW'(1);
                    day_next  = 5'd1;
                    if (month_reg >= cdt_pkg::MON_DEC)
                    begin
                        month_next = cdt_pkg::MON_JAN;
                        year_next  = year_reg + DW'(1);
                        ymod_next  = (ymod_reg == cdt_pkg::GREG_CYCLE_LAST) ? '0
                                     : ymod_reg + RW'(1);
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
        year_reg   <= year_next;
        ymod_reg   <= ymod_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        days_reg   <= days_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    ap_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("request accepted but block not busy");
    ap_done_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_WALK) && !busy) else $error("done out of sequence");
    ap_walk_month_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (month_reg != 4'd0) && (month_reg <= cdt_pkg::MON_DEC))
        else $error("walk month out of range");
    ap_walk_ymod_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (ymod_reg < cdt_pkg::GREG_CYCLE))
        else $error("year cycle position out of range");
    ap_result_hour_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.sum_hour < 5'd24) && (result.sum_minute < 6'd60)
                 && (result.sum_second < 6'd60)) else $error("time of day out of range");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the date-time interval adder against a cycle-free model of the
// calendar sum: directed corner dates first, then paced random requests.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 2500;

    logic              clk;
    logic              rst_n;
    logic              start;
    cdt_pkg::request_t request;
    logic              busy;
    logic              done;
    cdt_pkg::result_t  result;

    cdt_pkg::result_t  expected_sums[$];
    int                mismatch_count;
    int                burst_left;

    calendar_datetime_add_interval dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(30_000_000);
        $display("Mismatches found");
        $finish;
    end

    function automatic int month_days(input int unsigned year, input int unsigned month);
        bit leap;
        leap = ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
        if (month == cdt_pkg::MON_FEB)
            return leap ? 29 : 28;
        if (month == cdt_pkg::MON_APR || month == cdt_pkg::MON_JUN ||
            month == cdt_pkg::MON_SEP || month == cdt_pkg::MON_NOV)
            return 30;
        return 31;
    endfunction

    // Leap years are judged on the full year, before it wraps to 16 bits.
    function automatic cdt_pkg::result_t predict_sum(input cdt_pkg::request_t req);
        int unsigned      year;
        int unsigned      month;
        int unsigned      carry;
        int unsigned      month_total;
        int               day;
        int               days_to_go;
        int               room;
        cdt_pkg::result_t sum;
        month = 32'(req.start_month);
        if (month == 0)
            month = 32'(cdt_pkg::MON_JAN);
        day = 32'(req.start_day);
        carry = 32'(req.start_second) + 32'(req.add_seconds);
        sum.sum_second = 6'(carry % 60);
        carry = 32'(req.start_minute) + 32'(req.add_minutes) + carry / 60;
        sum.sum_minute = 6'(carry % 60);
        carry = 32'(req.start_hour) + 32'(req.add_hours) + carry / 60;
        sum.sum_hour = 5'(carry % 24);
        days_to_go = 32'(req.add_days) + carry / 24;
        year = 32'(req.start_year) + 32'(req.add_years);
        month_total = month + 32'(req.add_months);
        year += (month_total - 1) / 12;
        month = (month_total - 1) % 12 + 1;
        // walk one month at a time; an unclamped day makes room negative
        while (days_to_go > 0)
        begin
            room = month_days(year, month) - day;
            if (days_to_go <= room)
            begin
                day += days_to_go;
                days_to_go = 0;
            end
            else
            begin
                days_to_go -= room + 1;
                day = 1;
                month++;
                if (month > cdt_pkg::MON_DEC)
                begin
                    month = 32'(cdt_pkg::MON_JAN);
                    year++;
                end
            end
        end
        sum.sum_year      = 16'(year);
        sum.sum_month     = 4'(month);
        sum.sum_day       = 5'(day);
        sum.year_overflow = (year > 65535);
        return sum;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Results are taken first so a done and a new request at one edge keep order.
    always @(posedge clk)
    begin : track_sums
        cdt_pkg::result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_sums.size() == 0)
                begin
                    $error("sum returned with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    check_field("sum_year", want.sum_year, result.sum_year);
                    check_field("sum_month", 16'(want.sum_month), 16'(result.sum_month));
                    check_field("sum_day", 16'(want.sum_day), 16'(result.sum_day));
                    check_field("sum_hour", 16'(want.sum_hour), 16'(result.sum_hour));
                    check_field("sum_minute", 16'(want.sum_minute), 16'(result.sum_minute));
                    check_field("sum_second", 16'(want.sum_second), 16'(result.sum_second));
                    check_field("year_overflow", 16'(want.year_overflow),
                                16'(result.year_overflow));
                end
            end
            if (start && !busy)
                expected_sums.push_back(predict_sum(request));
        end
    end

    function automatic cdt_pkg::request_t make_request(
        input int y, input int mo, input int d, input int h, input int mi, input int s,
        input int ay, input int am, input int ad, input int ah, input int amin,
        input int asec);
        cdt_pkg::request_t req;
        req.start_year   = 16'(y);
        req.start_month  = 4'(mo);
        req.start_day    = 5'(d);
        req.start_hour   = 5'(h);
        req.start_minute = 6'(mi);
        req.start_second = 6'(s);
        req.add_years    = 12'(ay);
        req.add_months   = 12'(am);
        req.add_days     = 16'(ad);
        req.add_hours    = 16'(ah);
        req.add_minutes  = 16'(amin);
        req.add_seconds  = 16'(asec);
        return req;
    endfunction

    // Hold start until the request is taken, then idle between bursts.
    task automatic send_request(input cdt_pkg::request_t req);
        int gap;
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 6);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 300)
                                              : $urandom_range(1, 20);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop start so the last request is not taken again, then wait for every sum.
    task automatic wait_all_returned();
        @(negedge clk);
        start <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_basic_carries();
        send_request(make_request(2000, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(1999, 12, 31, 23, 59, 59, 0, 0, 0, 0, 0, 1));
        send_request(make_request(2023, 6, 15, 10, 20, 30, 0, 0, 0, 0, 0, 65535));
        send_request(make_request(2023, 6, 15, 10, 20, 30, 0, 0, 0, 0, 65535, 0));
        send_request(make_request(2023, 6, 15, 10, 20, 30, 0, 0, 0, 65535, 0, 0));
        send_request(make_request(2012, 12, 5, 3, 4, 5, 0, 4095, 0, 0, 0, 0));
        send_request(make_request(1, 3, 9, 0, 0, 0, 4095, 0, 65535, 0, 0, 0));
    endtask

    task automatic test_leap_years();
        send_request(make_request(0, 2, 28, 12, 0, 0, 0, 0, 1, 0, 0, 0));
        send_request(make_request(1900, 2, 28, 12, 0, 0, 0, 0, 1, 0, 0, 0));
        send_request(make_request(2000, 2, 28, 12, 0, 0, 0, 0, 1, 0, 0, 0));
        send_request(make_request(2024, 2, 29, 8, 0, 0, 1, 0, 0, 0, 0, 0));
    endtask

    task automatic test_unclamped_days();
        send_request(make_request(2021, 1, 31, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        send_request(make_request(2021, 1, 31, 0, 0, 0, 0, 1, 1, 0, 0, 0));
        send_request(make_request(2021, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(2021, 5, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        send_request(make_request(2021, 4, 31, 0, 0, 0, 0, 0, 3, 0, 0, 0));
        // pause here until every outstanding sum is back
        wait_all_returned();
    endtask

    task automatic test_odd_start_fields();
        send_request(make_request(2010, 0, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(2010, 13, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(2010, 15, 10, 0, 0, 0, 0, 11, 40, 0, 0, 0));
        send_request(make_request(2010, 7, 10, 31, 63, 63, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_year_overflow();
        send_request(make_request(65535, 12, 31, 23, 59, 59, 0, 0, 0, 0, 0, 1));
        send_request(make_request(65535, 12, 31, 0, 0, 0, 0, 0, 60, 0, 0, 0));
        send_request(make_request(65535, 15, 31, 31, 63, 63, 4095, 4095, 65535, 65535,
                                  65535, 65535));
    endtask

    task automatic test_random_sums();
        cdt_pkg::request_t req;
        bool_loop: for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            req = cdt_pkg::request_t'(0);
            if ($urandom_range(0, 1) == 0)
                req.start_year = 16'($urandom_range(1890, 2110));
            else
                req.start_year = 16'($urandom());
            if ($urandom_range(0, 6) != 0)
            begin
                req.start_month  = 4'($urandom_range(1, 12));
                req.start_day    = 5'($urandom_range(1, 31));
                req.start_hour   = 5'($urandom_range(0, 23));
                req.start_minute = 6'($urandom_range(0, 59));
                req.start_second = 6'($urandom_range(0, 59));
            end
            else
            begin
                req.start_month  = 4'($urandom_range(0, 15));
                req.start_day    = 5'($urandom_range(0, 31));
                req.start_hour   = 5'($urandom_range(0, 31));
                req.start_minute = 6'($urandom_range(0, 63));
                req.start_second = 6'($urandom_range(0, 63));
            end
            req.add_years  = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 50))
                                                         : 12'($urandom());
            req.add_months = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 30))
                                                         : 12'($urandom());
            // keep most day walks short; a few run the full range
            case ($urandom_range(0, 19))
                0, 1, 2:    req.add_days = 16'($urandom());
                3, 4, 5, 6: req.add_days = 16'($urandom_range(0, 5000));
                default:    req.add_days = 16'($urandom_range(0, 400));
            endcase
            req.add_hours   = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                          : 16'($urandom_range(0, 100));
            req.add_minutes = ($urandom_range(0, 2) == 0) ? 16'($urandom())
                                                          : 16'($urandom_range(0, 200));
            req.add_seconds = ($urandom_range(0, 2) == 0) ? 16'($urandom())
                                                          : 16'($urandom_range(0, 200));
            send_request(req);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = cdt_pkg::request_t'(0);
        mismatch_count = 0;
        burst_left     = 1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_carries();
        test_leap_years();
        test_unclamped_days();
        test_odd_start_fields();
        test_year_overflow();
        test_random_sums();

        wait_all_returned();
        // catch any stray sum after the last one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/cdt_pkg.sv
hdl/cdt_div.sv
hdl/calendar_datetime_add_interval.sv
verif/tb.sv
